// ===== rtl/core/esss_pkg.sv =====
// Shared types and constants for the eye-scan sweep sequencer.
`timescale 1ns / 1ps

package esss_pkg;

   localparam int unsigned CSR_DATA_W = 12;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned BITS_W     = 55;

   localparam logic signed [7:0]  VERT_MAX = 8'sd127;
   localparam logic signed [7:0]  VERT_MIN = -8'sd127;
   localparam logic signed [11:0] HORZ_MAX = 12'sd2047;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HORZ_START = 3'd0,
      CSR_HORZ_STOP  = 3'd1,
      CSR_HORZ_STEP  = 3'd2,
      CSR_VERT_START = 3'd3,
      CSR_VERT_STOP  = 3'd4,
      CSR_VERT_STEP  = 3'd5,
      CSR_INT_WIDTH  = 3'd6,
      CSR_PRESCALE   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      STAT_IDLE  = 3'd0,
      STAT_BUSY  = 3'd1,
      STAT_CONT  = 3'd2,
      STAT_DONE  = 3'd3,
      STAT_START = 3'd4
   } status_type;

   typedef struct packed {
      logic signed [11:0] horz_start;
      logic signed [11:0] horz_stop;
      logic [10:0]        horz_step;
      logic signed [7:0]  vert_start;
      logic signed [7:0]  vert_stop;
      logic [6:0]         vert_step;
      logic [6:0]         internal_width;
      logic [4:0]         prescale;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic signed [11:0] point_x;
      logic signed [7:0]  point_y;
      logic               point_ut_sign;
      logic [15:0]        point_errors;
      logic [BITS_W-1:0]  point_bits;
      logic [11:0]        horz_code;
      logic               vert_neg;
      logic [6:0]         vert_code;
      logic               ut_sign_ctl;
      logic               start_measure;
   } rsp_type;

endpackage

// ===== rtl/core/eye_scan_sweep_sequencer_top.sv =====
// Top level of the eye-scan sweep sequencer.
`timescale 1ns / 1ps

// Eye-scan sweep sequencer. Every request transaction yields exactly one
// response transaction, in the cycle after acceptance: the next-point logic
// (a 16x7 multiply plus shift for the bit count, and the offset step and
// saturate compares) sits between the request port and a single result
// register. A new request is taken every cycle unless a result is waiting
// with rsp_stall high, so sustained rate is one transaction per clock.
// func 0 starts a sweep (status 4); func 1 polls and, once measure_done is
// set, reports the point (status 2, or 3 at the end of the sweep) and moves
// to the next offset, or first to the other sign in DFE mode. The control
// outputs (horz_code, vert_neg, vert_code, ut_sign_ctl) always show the
// offsets for the next measurement. Registers are written through the csr_
// port and should only change while no transaction is in flight.

module eye_scan_sweep_sequencer_top
   import esss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic                  req_measure_done,
   input  logic [15:0]           req_err_count,
   input  logic [15:0]           req_samp_count,
   input  logic                  req_dfe_mode,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic signed [11:0]    rsp_point_x,
   output logic signed [7:0]     rsp_point_y,
   output logic                  rsp_point_ut_sign,
   output logic [15:0]           rsp_point_errors,
   output logic [BITS_W-1:0]     rsp_point_bits,
   output logic [11:0]           rsp_horz_code,
   output logic                  rsp_vert_neg,
   output logic [6:0]            rsp_vert_code,
   output logic                  rsp_ut_sign_ctl,
   output logic                  rsp_start_measure
);

   cfg_type cfg;
   rsp_type rsp_next;
   rsp_type rsp_data;
   logic    out_busy;
   logic    req_accept;

   // stall only while the result register is full and stalled downstream
   assign req_stall  = out_busy;
   assign req_accept = req_valid & ~out_busy;

   esss_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   esss_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .req_func         (req_func),
      .req_measure_done (req_measure_done),
      .req_err_count    (req_err_count),
      .req_samp_count   (req_samp_count),
      .req_dfe_mode     (req_dfe_mode),
      .cfg              (cfg),
      .rsp              (rsp_next)
   );

   esss_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .rsp_next  (rsp_next),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .busy      (out_busy),
      .rsp_data  (rsp_data)
   );

   assign rsp_status        = rsp_data.status;
   assign rsp_point_x       = rsp_data.point_x;
   assign rsp_point_y       = rsp_data.point_y;
   assign rsp_point_ut_sign = rsp_data.point_ut_sign;
   assign rsp_point_errors  = rsp_data.point_errors;
   assign rsp_point_bits    = rsp_data.point_bits;
   assign rsp_horz_code     = rsp_data.horz_code;
   assign rsp_vert_neg      = rsp_data.vert_neg;
   assign rsp_vert_code     = rsp_data.vert_code;
   assign rsp_ut_sign_ctl   = rsp_data.ut_sign_ctl;
   assign rsp_start_measure = rsp_data.start_measure;

endmodule

// ===== rtl/core/esss_cfg.sv =====
// Configuration register file of the eye-scan sweep sequencer.
`timescale 1ns / 1ps

module esss_cfg
   import esss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_HORZ_START: cfg_in.horz_start     = $signed(csr_data[11:0]);
            CSR_HORZ_STOP:  cfg_in.horz_stop      = $signed(csr_data[11:0]);
            CSR_HORZ_STEP:  cfg_in.horz_step      = csr_data[10:0];
            CSR_VERT_START: cfg_in.vert_start     = $signed(csr_data[7:0]);
            CSR_VERT_STOP:  cfg_in.vert_stop      = $signed(csr_data[7:0]);
            CSR_VERT_STEP:  cfg_in.vert_step      = csr_data[6:0];
            CSR_INT_WIDTH:  cfg_in.internal_width = csr_data[6:0];
            CSR_PRESCALE:   cfg_in.prescale       = csr_data[4:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.horz_start     <= 12'sd0;
         cfg_ff.horz_stop      <= 12'sd0;
         cfg_ff.horz_step      <= 11'd1;
         cfg_ff.vert_start     <= 8'sd0;
         cfg_ff.vert_stop      <= 8'sd0;
         cfg_ff.vert_step      <= 7'd1;
         cfg_ff.internal_width <= 7'd32;
         cfg_ff.prescale       <= 5'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/esss_seq.sv =====
// Sweep state registers and the per-transaction next-point logic.
`timescale 1ns / 1ps

module esss_seq
   import esss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        req_func,
   input  logic        req_measure_done,
   input  logic [15:0] req_err_count,
   input  logic [15:0] req_samp_count,
   input  logic        req_dfe_mode,
   input  cfg_type     cfg,
   output rsp_type     rsp
);

   logic              running_ff, running_in;
   logic signed [11:0] horz_ff, horz_in;
   logic signed [7:0]  vert_ff, vert_in;
   logic              ut_sign_ff, ut_sign_in;
   logic              dfe_on_ff, dfe_on_in;

   logic signed [7:0]  vert_start_c;
   logic signed [8:0]  vert_sum;
   logic signed [7:0]  vert_step_sat;
   logic signed [12:0] horz_sum;
   logic signed [11:0] horz_step_sat;
   logic [22:0]        samp_prod;
   logic [5:0]         shamt;
   logic [BITS_W-1:0]  bits;
   logic [7:0]         vert_mag;

   // -128 is outside the offset range
   assign vert_start_c  = (cfg.vert_start < VERT_MIN) ? VERT_MIN : cfg.vert_start;
   assign vert_sum      = {vert_ff[7], vert_ff} + $signed({2'b00, cfg.vert_step});
   assign vert_step_sat = (vert_sum > 9'sd127) ? VERT_MAX : vert_sum[7:0];
   assign horz_sum      = {horz_ff[11], horz_ff} + $signed({2'b00, cfg.horz_step});
   assign horz_step_sat = (horz_sum > 13'sd2047) ? HORZ_MAX : horz_sum[11:0];

   assign samp_prod = 23'(req_samp_count) * 23'(cfg.internal_width);
   assign shamt     = 6'd1 + {1'b0, cfg.prescale};
   assign bits      = BITS_W'(samp_prod) << shamt;

   always_comb begin
      running_in = running_ff;
      horz_in    = horz_ff;
      vert_in    = vert_ff;
      ut_sign_in = ut_sign_ff;
      dfe_on_in  = dfe_on_ff;

      rsp               = '0;
      rsp.status        = STAT_IDLE;

      priority if (!req_func) begin
         running_in        = 1'b1;
         horz_in           = cfg.horz_start;
         vert_in           = vert_start_c;
         ut_sign_in        = 1'b0;
         dfe_on_in         = req_dfe_mode;
         rsp.status        = STAT_START;
         rsp.start_measure = 1'b1;
      end else if (!running_ff) begin
         rsp.status = STAT_IDLE;
      end else if (!req_measure_done) begin
         rsp.status = STAT_BUSY;
      end else begin
         rsp.point_x       = horz_ff;
         rsp.point_y       = vert_ff;
         rsp.point_ut_sign = ut_sign_ff;
         rsp.point_errors  = req_err_count;
         rsp.point_bits    = bits;
         rsp.status        = STAT_CONT;
         rsp.start_measure = 1'b1;
         // DFE: second pass at the same offsets with the other sign
         priority if (!ut_sign_ff && dfe_on_ff) begin
            ut_sign_in = 1'b1;
         end else begin
            ut_sign_in = 1'b0;
            priority if (vert_ff < cfg.vert_stop) begin
               vert_in = vert_step_sat;
            end else begin
               vert_in = vert_start_c;
               priority if (horz_ff < cfg.horz_stop) begin
                  horz_in = horz_step_sat;
               end else begin
                  running_in        = 1'b0;
                  rsp.status        = STAT_DONE;
                  rsp.start_measure = 1'b0;
               end
            end
         end
      end

      // controls reflect the state after this transaction
      vert_mag        = vert_in[7] ? 8'(-vert_in) : 8'(vert_in);
      rsp.horz_code   = horz_in;
      rsp.vert_neg    = vert_in[7];
      rsp.vert_code   = vert_mag[6:0];
      rsp.ut_sign_ctl = ut_sign_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         horz_ff    <= 12'sd0;
         vert_ff    <= 8'sd0;
         ut_sign_ff <= 1'b0;
         dfe_on_ff  <= 1'b0;
      end else if (accept) begin
         running_ff <= running_in;
         horz_ff    <= horz_in;
         vert_ff    <= vert_in;
         ut_sign_ff <= ut_sign_in;
         dfe_on_ff  <= dfe_on_in;
      end
   end

endmodule

// ===== rtl/core/esss_out.sv =====
// Result register of the eye-scan sweep sequencer.
`timescale 1ns / 1ps

module esss_out
   import esss_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type rsp_next,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output logic    busy,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign valid_in = load | (valid_ff & rsp_stall);
   // a held result blocks new transactions only while it is stalled
   assign busy     = valid_ff & rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/core/esss_checker.sv =====
// Port-level assertions for the eye-scan sweep sequencer, bound to the top level.
`timescale 1ns / 1ps

module esss_checker
   import esss_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_func,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [2:0]        rsp_status,
   input logic [BITS_W-1:0] rsp_point_bits,
   input logic              rsp_start_measure
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response changed");

   // every accepted request yields a response on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   a_start_status: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_func |=> rsp_status == STAT_START)
      else $error("start transaction did not report started");

   a_start_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_start_measure ==
         (rsp_status == STAT_CONT || rsp_status == STAT_START))
      else $error("start_measure disagrees with status");

   a_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_CONT && rsp_status != STAT_DONE
         |-> rsp_point_bits == '0)
      else $error("point fields set without a reported point");

endmodule

bind eye_scan_sweep_sequencer_top esss_checker u_esss_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_func          (req_func),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_point_bits    (rsp_point_bits),
   .rsp_start_measure (rsp_start_measure)
);
